>>> src/demand_paging_frame_manager_macros.svh
// Assertion helpers shared by the frame manager RTL
`ifndef DEMAND_PAGING_FRAME_MANAGER_MACROS_SVH
`define DEMAND_PAGING_FRAME_MANAGER_MACROS_SVH

// Property holds at every clock edge outside reset
`define DPFM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition never holds outside reset
`define DPFM_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> src/dpfm_pkg.sv
package dpfm_pkg;

  // Default sizing
  localparam int unsigned DEF_MAX_PAGES      = 64;
  localparam int unsigned DEF_MAX_FRAMES     = 16;
  localparam int unsigned DEF_MAX_SWAP_SLOTS = 64;
  localparam int unsigned DEF_MAX_PAGE_SHIFT = 12;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_PAGE_SHIFT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_PAGES  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_PAGES  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SWAP_SLOTS  = 3'd5;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_RANGE     = 3'd1;
  localparam logic [2:0] ST_READ_ONLY = 3'd2;
  localparam logic [2:0] ST_SWAP_FULL = 3'd3;
  localparam logic [2:0] ST_LOST      = 3'd4;

  // Fill sources
  localparam logic [1:0] FILL_NONE = 2'd0;
  localparam logic [1:0] FILL_EXEC = 2'd1;
  localparam logic [1:0] FILL_ZERO = 2'd2;
  localparam logic [1:0] FILL_SWAP = 2'd3;

  typedef struct packed {
    logic        cmd;
    logic [17:0] address;
  } dpfm_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  fill_source;
    logic [5:0]  fill_slot;
    logic [5:0]  page_index;
    logic [3:0]  frame_index;
    logic [15:0] phys_address;
    logic        evicted;
    logic [5:0]  evicted_page;
    logic        writeback;
    logic [5:0]  writeback_slot;
  } dpfm_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_ENTRY,
    S_FRD,
    S_FCMP,
    S_PRD,
    S_PCMP,
    S_SRD,
    S_SCMP,
    S_STAMP,
    S_FILL,
    S_STORE,
    S_FINISH
  } dpfm_state_t;

endpackage

>>> src/dpfm_ram.sv
module dpfm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/demand_paging_frame_manager.sv
// Demand-paging frame manager: one byte load or store per item, one result item each.
// Page table and frame stamps sit in two single-port-write RAMs with a registered read;
// the swap map is a bit vector read one slot a cycle through a register. A reset clears
// per-entry valid flags and the swap map, so no clearing pass is needed.
// Errors and hits go straight to the report. A fault walks the frame stamps, then on a full
// memory the page table and for a dirty victim the swap map, then fills and reports.
// One item is in flight at a time; a finished result waits in the output register while
// the next item is taken.
`include "demand_paging_frame_manager_macros.svh"

module demand_paging_frame_manager #(
  parameter int unsigned MAX_PAGES      = dpfm_pkg::DEF_MAX_PAGES,
  parameter int unsigned MAX_FRAMES     = dpfm_pkg::DEF_MAX_FRAMES,
  parameter int unsigned MAX_SWAP_SLOTS = dpfm_pkg::DEF_MAX_SWAP_SLOTS,
  parameter int unsigned MAX_PAGE_SHIFT = dpfm_pkg::DEF_MAX_PAGE_SHIFT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  dpfm_pkg::dpfm_in_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output dpfm_pkg::dpfm_out_t                 out_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dpfm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dpfm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import dpfm_pkg::*;

  localparam int unsigned PW = $clog2(MAX_PAGES);
  localparam int unsigned FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned SW = (MAX_SWAP_SLOTS > 1) ? $clog2(MAX_SWAP_SLOTS) : 1;
  localparam int unsigned LW = (FW > SW) ? FW : SW;
  localparam int unsigned EW = LW + 3;
  // entry layout: valid, dirty, lost, location
  localparam int unsigned E_V = EW - 1;
  localparam int unsigned E_D = EW - 2;
  localparam int unsigned E_L = EW - 3;

  // Configuration registers
  logic [3:0] page_shift_r;
  logic [6:0] page_count_r, text_pages_r, data_pages_r, swap_slots_r;
  logic [4:0] frame_count_r;

  // Control and item registers
  dpfm_state_t state_r, state_nxt;
  logic        cmd_r, cmd_nxt;
  logic [17:0] addr_r, addr_nxt;
  logic [PW-1:0] page_r, page_nxt;
  logic        text_r, text_nxt;
  logic [EW-1:0] cur_r, cur_nxt;
  logic [EW-1:0] vent_r, vent_nxt;
  logic [1:0]  src_r, src_nxt;
  logic [LW-1:0] slot_r, slot_nxt;
  logic [FW-1:0] vic_r, vic_nxt;
  logic [31:0] best_r, best_nxt;
  logic [FW:0] fidx_r, fidx_nxt;
  logic [PW:0] pidx_r, pidx_nxt;
  logic [SW:0] sidx_r, sidx_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  dpfm_out_t   res_r, res_nxt;
  logic        out_valid_r, out_valid_nxt;
  dpfm_out_t   out_item_r, out_item_nxt;

  // Valid flags for the RAM entries
  logic [MAX_PAGES-1:0]      pv_r;
  logic [MAX_FRAMES-1:0]     fv_r;

  // Swap map and its registered read
  logic [MAX_SWAP_SLOTS-1:0] swap_used_r;
  logic                      sw_rdata_r;

  // RAM ports
  logic          pt_we;
  logic [PW-1:0] pt_waddr, pt_raddr;
  logic [EW-1:0] pt_wdata, pt_rdata;
  logic          st_we;
  logic [FW-1:0] st_waddr, st_raddr;
  logic [31:0]   st_wdata, st_rdata;
  logic          sw_we;
  logic [SW-1:0] sw_waddr, sw_raddr;
  logic          sw_wdata;

  dpfm_ram #(.WIDTH(EW), .DEPTH(MAX_PAGES)) u_page_ram (
    .clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
    .raddr(pt_raddr), .rdata(pt_rdata)
  );
  dpfm_ram #(.WIDTH(32), .DEPTH(MAX_FRAMES)) u_stamp_ram (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  // Swap map: one bit per slot, one slot read per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swap_used_r <= '0;
    end else if (sw_we) begin
      swap_used_r[sw_waddr] <= sw_wdata;
    end
    sw_rdata_r <= swap_used_r[sw_raddr];
  end

  // Clamped configuration
  logic [4:0]  shift_c;
  logic [PW:0] np_c;
  logic [FW:0] nf_c;
  logic [SW:0] ns_c;
  always_comb begin
    shift_c = (32'(page_shift_r) > MAX_PAGE_SHIFT) ? 5'(MAX_PAGE_SHIFT) : 5'(page_shift_r);
    np_c = (32'(page_count_r) > MAX_PAGES) ? (PW+1)'(MAX_PAGES) : (PW+1)'(page_count_r);
    if (frame_count_r == 5'd0) begin
      nf_c = (FW+1)'(1);
    end else if (32'(frame_count_r) > MAX_FRAMES) begin
      nf_c = (FW+1)'(MAX_FRAMES);
    end else begin
      nf_c = (FW+1)'(frame_count_r);
    end
    ns_c = (32'(swap_slots_r) > MAX_SWAP_SLOTS) ? (SW+1)'(MAX_SWAP_SLOTS)
                                                : (SW+1)'(swap_slots_r);
  end

  // Address split
  logic [31:0] limit_w, page_w, offset_w, phys_w, frame_w;
  logic [FW-1:0] frame_sel;
  logic [EW-1:0] ent_w;
  logic [31:0] cnt_inc;
  always_comb begin
    limit_w  = 32'(np_c) << shift_c;
    page_w   = 32'(addr_r) >> shift_c;
    offset_w = 32'(addr_r) & ~(32'hFFFF_FFFF << shift_c);
    frame_w  = 32'(frame_sel);
    phys_w   = (frame_w << shift_c) + offset_w;
    cnt_inc  = (cnt_r == 32'hFFFF_FFFF) ? cnt_r : cnt_r + 32'd1;
  end

  // Main sequencer
  always_comb begin
    logic [31:0] pnum;
    logic [31:0] vpage;
    logic        used;
    state_nxt = state_r;
    cmd_nxt = cmd_r;
    addr_nxt = addr_r;
    page_nxt = page_r;
    text_nxt = text_r;
    cur_nxt = cur_r;
    vent_nxt = vent_r;
    src_nxt = src_r;
    slot_nxt = slot_r;
    vic_nxt = vic_r;
    best_nxt = best_r;
    fidx_nxt = fidx_r;
    pidx_nxt = pidx_r;
    sidx_nxt = sidx_r;
    cnt_nxt = cnt_r;
    res_nxt = res_r;
    out_item_nxt = out_item_r;
    out_valid_nxt = out_valid_r & out_stall;
    pt_we = 1'b0; pt_waddr = page_r; pt_wdata = '0; pt_raddr = page_r;
    st_we = 1'b0; st_waddr = vic_r; st_wdata = cnt_r; st_raddr = fidx_r[FW-1:0];
    sw_we = 1'b0; sw_waddr = sidx_r[SW-1:0]; sw_wdata = 1'b0; sw_raddr = sidx_r[SW-1:0];
    frame_sel = vic_r;
    ent_w = '0;
    pnum = 32'(pidx_r);
    vpage = 32'(page_r);
    used = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt = in_item.cmd;
          addr_nxt = in_item.address;
          res_nxt = '0;
          state_nxt = S_CHECK;
        end
      end
      // Range and permission, then look up the page entry
      S_CHECK: begin
        page_nxt = page_w[PW-1:0];
        text_nxt = page_w < 32'(text_pages_r);
        pt_raddr = page_w[PW-1:0];
        if (32'(addr_r) >= limit_w) begin
          res_nxt.status = ST_RANGE;
          state_nxt = S_FINISH;
        end else begin
          res_nxt.page_index = page_w[5:0];
          if (cmd_r && (page_w < 32'(text_pages_r))) begin
            res_nxt.status = ST_READ_ONLY;
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_ENTRY;
          end
        end
      end
      S_ENTRY: begin
        ent_w = pv_r[page_r] ? pt_rdata : '0;
        cur_nxt = ent_w;
        frame_sel = ent_w[FW-1:0];
        slot_nxt = ent_w[LW-1:0];
        fidx_nxt = '0;
        if (ent_w[E_V]) begin
          // hit: a store marks dirty and restamps
          res_nxt.frame_index = frame_w[3:0];
          res_nxt.phys_address = phys_w[15:0];
          if (cmd_r) begin
            pt_we = 1'b1;
            pt_wdata = ent_w | (EW'(1) << E_D);
            st_we = 1'b1;
            st_waddr = ent_w[FW-1:0];
            cnt_nxt = cnt_inc;
          end
          state_nxt = S_FINISH;
        end else if (!text_r && ent_w[E_L]) begin
          res_nxt.status = ST_LOST;
          state_nxt = S_FINISH;
        end else begin
          if (text_r) begin
            src_nxt = FILL_EXEC;
          end else if (!ent_w[E_D]) begin
            src_nxt = (vpage < (32'(text_pages_r) + 32'(data_pages_r))) ? FILL_EXEC : FILL_ZERO;
          end else begin
            src_nxt = FILL_SWAP;
          end
          state_nxt = S_FRD;
        end
      end
      // Frame walk: first free frame, else least stamp
      S_FRD: begin
        if (!fv_r[fidx_r[FW-1:0]]) begin
          vic_nxt = fidx_r[FW-1:0];
          state_nxt = S_STAMP;
        end else begin
          state_nxt = S_FCMP;
        end
      end
      S_FCMP: begin
        if ((fidx_r == '0) || (st_rdata < best_r)) begin
          best_nxt = st_rdata;
          vic_nxt = fidx_r[FW-1:0];
        end
        pidx_nxt = '0;
        if (fidx_r + 1'b1 == nf_c) begin
          state_nxt = S_PRD;
        end else begin
          fidx_nxt = fidx_r + 1'b1;
          state_nxt = S_FRD;
        end
      end
      // Page walk for the victim's owner
      S_PRD: begin
        pt_raddr = pidx_r[PW-1:0];
        state_nxt = S_PCMP;
      end
      S_PCMP: begin
        ent_w = pv_r[pidx_r[PW-1:0]] ? pt_rdata : '0;
        if (ent_w[E_V] && (ent_w[LW-1:0] == LW'(vic_r))) begin
          res_nxt.evicted = 1'b1;
          res_nxt.evicted_page = pnum[5:0];
          vent_nxt = ent_w;
          sidx_nxt = '0;
          if (ent_w[E_D] && (pnum >= 32'(text_pages_r))) begin
            state_nxt = S_SRD;
          end else begin
            pt_we = 1'b1;
            pt_waddr = pidx_r[PW-1:0];
            pt_wdata = ent_w & ~((EW'(1) << E_V) | (EW'(1) << E_D));
            state_nxt = S_STAMP;
          end
        end else if (pnum + 32'd1 == MAX_PAGES) begin
          state_nxt = S_STAMP;
        end else begin
          pidx_nxt = pidx_r + 1'b1;
          state_nxt = S_PRD;
        end
      end
      // Swap walk for the dirty victim
      S_SRD: begin
        if (sidx_r >= ns_c) begin
          pt_we = 1'b1;
          pt_waddr = pidx_r[PW-1:0];
          pt_wdata = (vent_r & ~(EW'(1) << E_V)) | (EW'(1) << E_L);
          res_nxt.status = ST_SWAP_FULL;
          state_nxt = S_STAMP;
        end else begin
          state_nxt = S_SCMP;
        end
      end
      S_SCMP: begin
        used = sw_rdata_r;
        if (!used) begin
          sw_we = 1'b1;
          sw_wdata = 1'b1;
          pt_we = 1'b1;
          pt_waddr = pidx_r[PW-1:0];
          pt_wdata = {1'b0, vent_r[E_D], vent_r[E_L], LW'(sidx_r[SW-1:0])};
          res_nxt.writeback = 1'b1;
          res_nxt.writeback_slot = 6'(32'(sidx_r));
          state_nxt = S_STAMP;
        end else begin
          sidx_nxt = sidx_r + 1'b1;
          state_nxt = S_SRD;
        end
      end
      // Stamp counter step for taking the frame; release the swap slot being read
      S_STAMP: begin
        cnt_nxt = cnt_inc;
        res_nxt.fill_source = src_r;
        if (src_r == FILL_SWAP) begin
          res_nxt.fill_slot = 6'(32'(slot_r));
          if (32'(slot_r) < MAX_SWAP_SLOTS) begin
            sw_we = 1'b1;
            sw_waddr = SW'(slot_r);
            sw_wdata = 1'b0;
          end
        end
        state_nxt = S_FILL;
      end
      S_FILL: begin
        st_we = 1'b1;
        cnt_nxt = cnt_inc;
        pt_we = 1'b1;
        pt_wdata = {1'b1,
                    cmd_r | (~text_r & cur_r[E_D]),
                    ~text_r & cur_r[E_L],
                    LW'(vic_r)};
        res_nxt.frame_index = frame_w[3:0];
        res_nxt.phys_address = phys_w[15:0];
        state_nxt = cmd_r ? S_STORE : S_FINISH;
      end
      S_STORE: begin
        st_we = 1'b1;
        cnt_nxt = cnt_inc;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_item_nxt = res_r;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= 32'd1;
      out_valid_r <= 1'b0;
      pv_r <= '0;
      fv_r <= '0;
      page_shift_r <= 4'd4;
      page_count_r <= 7'd64;
      text_pages_r <= 7'd0;
      data_pages_r <= 7'd0;
      frame_count_r <= 5'd16;
      swap_slots_r <= 7'd64;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (pt_we) pv_r[pt_waddr] <= 1'b1;
      if (st_we) fv_r[st_waddr] <= 1'b1;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_PAGE_SHIFT:  page_shift_r <= cfg_data[3:0];
          REG_PAGE_COUNT:  page_count_r <= cfg_data;
          REG_TEXT_PAGES:  text_pages_r <= cfg_data;
          REG_DATA_PAGES:  data_pages_r <= cfg_data;
          REG_FRAME_COUNT: frame_count_r <= cfg_data[4:0];
          REG_SWAP_SLOTS:  swap_slots_r <= cfg_data;
          default: ;
        endcase
      end
    end
    cmd_r <= cmd_nxt;
    addr_r <= addr_nxt;
    page_r <= page_nxt;
    text_r <= text_nxt;
    cur_r <= cur_nxt;
    vent_r <= vent_nxt;
    src_r <= src_nxt;
    slot_r <= slot_nxt;
    vic_r <= vic_nxt;
    best_r <= best_nxt;
    fidx_r <= fidx_nxt;
    pidx_r <= pidx_nxt;
    sidx_r <= sidx_nxt;
    res_r <= res_nxt;
    out_item_r <= out_item_nxt;
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item = out_item_r;
  assign cfg_ready = 1'b1;

  // Checks
  `DPFM_NEVER(a_stamp_nonzero, cnt_r == 32'd0, "stamp counter reached zero")
  `DPFM_ASSERT(a_out_from_finish, $rose(out_valid_r) |-> $past(state_r) == S_FINISH, "stray result")
  `DPFM_ASSERT(a_frames_stay_used, $countones(fv_r) >= $past($countones(fv_r)), "frame freed")
  `DPFM_ASSERT(a_idle_holds, (state_r == S_IDLE) && !in_valid |=> state_r == S_IDLE, "left idle")

endmodule

>>> tb/dpfm_checker.sv
// Scoreboard for the frame manager: mirrors page table, frame stamps and swap map,
// predicts one result per accepted item and compares results in order.
module dpfm_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  logic                                  in_stall,
  input  dpfm_pkg::dpfm_in_t                    in_item,
  input  logic                                  out_valid,
  input  logic                                  out_stall,
  input  dpfm_pkg::dpfm_out_t                   out_item,
  input  logic                                  cfg_valid,
  input  logic                                  cfg_ready,
  input  logic [dpfm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dpfm_pkg::CFG_DATA_W-1:0]       cfg_data,
  output int                                    fails,
  output int                                    pending,
  output int                                    results_seen,
  output int                                    evictions,
  output int                                    writebacks,
  output int                                    swap_fills,
  output int                                    errors_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import dpfm_pkg::*;

  // mirrored block state
  bit          pg_valid [64];
  bit          pg_dirty [64];
  bit          pg_lost  [64];
  int unsigned pg_loc   [64];
  bit [31:0]   frame_stamp [16];
  bit          slot_used [64];
  bit [31:0]   stamp_ctr;

  // mirrored registers
  int unsigned r_shift, r_pages, r_text, r_data, r_frames, r_slots;

  dpfm_out_t expected_results[$];

  function automatic bit [31:0] bump_stamp();
    bit [31:0] s;
    s = stamp_ctr;
    if (stamp_ctr != 32'hFFFF_FFFF) stamp_ctr++;
    return s;
  endfunction

  // free frame first, else least-stamped; victim page goes to swap if dirty and writable
  task automatic claim_frame(inout dpfm_out_t r, output int unsigned frame);
    int unsigned nf, victim, ns, s;
    nf = (r_frames < 1) ? 1 : (r_frames > 16 ? 16 : r_frames);
    for (int f = 0; f < nf; f++) begin
      if (frame_stamp[f] == 0) begin
        frame_stamp[f] = bump_stamp();
        frame = f;
        return;
      end
    end
    victim = 0;
    for (int f = 1; f < nf; f++)
      if (frame_stamp[f] < frame_stamp[victim]) victim = f;
    for (int p = 0; p < 64; p++) begin
      if (pg_valid[p] && pg_loc[p] == victim) begin
        r.evicted = 1'b1;
        r.evicted_page = p[5:0];
        if (pg_dirty[p] && p >= r_text) begin
          ns = (r_slots > 64) ? 64 : r_slots;
          for (s = 0; s < ns; s++)
            if (!slot_used[s]) break;
          if (s < ns) begin
            slot_used[s] = 1'b1;
            pg_loc[p] = s;
            r.writeback = 1'b1;
            r.writeback_slot = s[5:0];
          end else begin
            pg_lost[p] = 1'b1;
            r.status = ST_SWAP_FULL;
          end
        end else begin
          pg_dirty[p] = 1'b0;
        end
        pg_valid[p] = 1'b0;
        break;
      end
    end
    frame_stamp[victim] = bump_stamp();
    frame = victim;
  endtask

  task automatic predict_access(input dpfm_in_t it, output dpfm_out_t r);
    int unsigned shift, np, addr, page, offs, frame, slot;
    logic [1:0]  src;
    bit          is_text;
    r = '0;
    shift = (r_shift > 12) ? 12 : r_shift;
    np = (r_pages > 64) ? 64 : r_pages;
    addr = it.address;
    if (addr >= (np << shift)) begin
      r.status = ST_RANGE;
      return;
    end
    page = addr >> shift;
    offs = addr & ((1 << shift) - 1);
    r.page_index = page[5:0];
    is_text = page < r_text;
    if (it.cmd && is_text) begin
      r.status = ST_READ_ONLY;
      return;
    end
    if (!pg_valid[page]) begin
      slot = 0;
      if (is_text) src = FILL_EXEC;
      else if (pg_lost[page]) begin
        r.status = ST_LOST;
        return;
      end else if (!pg_dirty[page]) src = (page < r_text + r_data) ? FILL_EXEC : FILL_ZERO;
      else begin
        src = FILL_SWAP;
        slot = pg_loc[page];
      end
      claim_frame(r, frame);
      if (src == FILL_SWAP) begin
        if (slot < 64) slot_used[slot] = 1'b0;
        r.fill_slot = slot[5:0];
      end
      r.fill_source = src;
      frame_stamp[frame] = bump_stamp();
      pg_valid[page] = 1'b1;
      pg_loc[page] = frame;
      if (is_text) begin
        pg_dirty[page] = 1'b0;
        pg_lost[page] = 1'b0;
      end
    end
    frame = pg_loc[page];
    if (it.cmd) begin
      pg_dirty[page] = 1'b1;
      if (frame < 16) frame_stamp[frame] = bump_stamp();
    end
    r.frame_index = frame[3:0];
    r.phys_address = 16'((frame << shift) + offs);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: %s got %0d, expected %0d", $realtime, what, got, want);
    fails++;
  endtask

  task automatic compare_result(input dpfm_out_t got, input dpfm_out_t want);
    if (got.status !== want.status) report_mismatch("status", got.status, want.status);
    if (got.fill_source !== want.fill_source)
      report_mismatch("fill_source", got.fill_source, want.fill_source);
    if (got.fill_slot !== want.fill_slot)
      report_mismatch("fill_slot", got.fill_slot, want.fill_slot);
    if (got.page_index !== want.page_index)
      report_mismatch("page_index", got.page_index, want.page_index);
    if (got.frame_index !== want.frame_index)
      report_mismatch("frame_index", got.frame_index, want.frame_index);
    if (got.phys_address !== want.phys_address)
      report_mismatch("phys_address", got.phys_address, want.phys_address);
    if (got.evicted !== want.evicted) report_mismatch("evicted", got.evicted, want.evicted);
    if (got.evicted_page !== want.evicted_page)
      report_mismatch("evicted_page", got.evicted_page, want.evicted_page);
    if (got.writeback !== want.writeback)
      report_mismatch("writeback", got.writeback, want.writeback);
    if (got.writeback_slot !== want.writeback_slot)
      report_mismatch("writeback_slot", got.writeback_slot, want.writeback_slot);
  endtask

  // watch all three channels at each edge
  always @(posedge clk) begin
    dpfm_out_t want;
    if (!rst_n) begin
      foreach (pg_valid[i]) begin
        pg_valid[i] = 0;
        pg_dirty[i] = 0;
        pg_lost[i] = 0;
        pg_loc[i] = 0;
        slot_used[i] = 0;
      end
      foreach (frame_stamp[i]) frame_stamp[i] = 0;
      stamp_ctr = 1;
      r_shift = 4;
      r_pages = 64;
      r_text = 0;
      r_data = 0;
      r_frames = 16;
      r_slots = 64;
      expected_results.delete();
      fails = 0;
      results_seen = 0;
      evictions = 0;
      writebacks = 0;
      swap_fills = 0;
      errors_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PAGE_SHIFT:  r_shift = cfg_data & 7'h0F;
          REG_PAGE_COUNT:  r_pages = cfg_data;
          REG_TEXT_PAGES:  r_text = cfg_data;
          REG_DATA_PAGES:  r_data = cfg_data;
          REG_FRAME_COUNT: r_frames = cfg_data & 7'h1F;
          REG_SWAP_SLOTS:  r_slots = cfg_data;
          default: ;
        endcase
      end
      // results first: a result never belongs to an item taken at the same edge
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result count", 1, 0);
        end else begin
          want = expected_results.pop_front();
          compare_result(out_item, want);
        end
        if (out_item.evicted) evictions++;
        if (out_item.writeback) writebacks++;
        if (out_item.fill_source == FILL_SWAP) swap_fills++;
        if (out_item.status != ST_OK) errors_seen++;
      end
      if (in_valid && !in_stall) begin
        predict_access(in_item, want);
        expected_results.push_back(want);
      end
    end
    pending = expected_results.size();
  end

endmodule

>>> tb/demand_paging_frame_manager_tb.sv
module demand_paging_frame_manager_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dpfm_pkg::*;

  localparam int STALL_LIMIT = 6000;

  // indexes outside the register list, expected to be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  dpfm_in_t              in_item = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  dpfm_out_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int fails, pending, results_seen, evictions, writebacks, swap_fills, errors_seen;
  int items_taken = 0;
  int cfg_taken = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  always #1 clk = ~clk;

  demand_paging_frame_manager u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  dpfm_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fails(fails), .pending(pending), .results_seen(results_seen), .evictions(evictions),
    .writebacks(writebacks), .swap_fills(swap_fills), .errors_seen(errors_seen)
  );

  // handshake counters, sampled with pre-edge values
  always @(posedge clk) begin
    if (in_valid && !in_stall) items_taken <= items_taken + 1;
    if (cfg_valid && cfg_ready) cfg_taken <= cfg_taken + 1;
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side: random stall, or a long hold when one is requested
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    int n0;
    n0 = cfg_taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    do @(negedge clk); while (cfg_taken == n0);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic setup_paging(input int sh, input int np, input int tx, input int dt,
                              input int nf, input int ns);
    write_reg(REG_PAGE_SHIFT, sh);
    write_reg(REG_PAGE_COUNT, np);
    write_reg(REG_TEXT_PAGES, tx);
    write_reg(REG_DATA_PAGES, dt);
    write_reg(REG_FRAME_COUNT, nf);
    write_reg(REG_SWAP_SLOTS, ns);
  endtask

  // offers one access; valid stays high across back-to-back items
  task automatic send_access(input logic cmd, input logic [17:0] addr);
    int n0;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    n0 = items_taken;
    in_valid <= 1'b1;
    in_item.cmd <= cmd;
    in_item.address <= addr;
    do @(negedge clk); while (items_taken == n0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // mostly in-range accesses over a small working set, some raw addresses
  task automatic random_accesses(input int cnt, input int sh, input int np);
    int eff_sh, eff_np, page, offs;
    logic [17:0] addr;
    eff_sh = (sh > 12) ? 12 : sh;
    eff_np = (np > 64) ? 64 : ((np < 1) ? 1 : np);
    repeat (cnt) begin
      if ($urandom_range(99) < 8) addr = 18'($urandom);
      else begin
        page = ($urandom_range(99) < 60) ? $urandom_range(eff_np - 1 < 7 ? eff_np - 1 : 7)
                                         : $urandom_range(eff_np - 1);
        offs = $urandom & ((1 << eff_sh) - 1);
        addr = 18'((page << eff_sh) | offs);
      end
      send_access(1'($urandom_range(1)), addr);
    end
  endtask

  initial begin
    int sh, np, tx, dt, nf, ns;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: small memory, two frames, one swap slot
    setup_paging(4, 8, 2, 2, 2, 1);
    write_reg(REG_SPARE_A, 7'h7F);
    write_reg(REG_SPARE_B, 7'h55);
    send_access(1'b0, 18'h00000);  // text fill
    send_access(1'b1, 18'h00005);  // store to read-only text
    send_access(1'b1, 18'h00025);  // data page from executable
    send_access(1'b1, 18'h00045);  // zero fill, clean text victim
    send_access(1'b1, 18'h00055);  // dirty victim to swap
    send_access(1'b1, 18'h00065);  // swap full, victim lost
    send_access(1'b0, 18'h00045);  // access to lost page
    send_access(1'b0, 18'h00025);  // refill from swap
    send_access(1'b0, 18'h0000F);  // text page refilled
    send_access(1'b0, 18'h00080);  // just past range
    send_access(1'b1, 18'h3FFFF);  // top address
    send_access(1'b1, 18'h0007F);  // last page
    send_access(1'b0, 18'h0002A);
    send_access(1'b1, 18'h0001F);
    send_access(1'b0, 18'h00010);
    send_access(1'b0, 18'h00000);
    send_access(1'b1, 18'h00000);
    drain();

    // random phases over several settings and idle patterns
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin sh = 0;  np = 1;   tx = 0;   dt = 0;   nf = 1;  ns = 0;   end
        1: begin sh = 12; np = 64;  tx = 64;  dt = 64;  nf = 16; ns = 64;  end
        2: begin sh = 15; np = 127; tx = 10;  dt = 20;  nf = 31; ns = 127; end
        3: begin sh = 6;  np = 40;  tx = 127; dt = 0;   nf = 0;  ns = 3;   end
        4: begin sh = 3;  np = 32;  tx = 4;   dt = 6;   nf = 4;  ns = 2;   end
        default: begin
          sh = $urandom_range(8, 1);
          np = $urandom_range(64, 8);
          tx = $urandom_range(8);
          dt = $urandom_range(8);
          nf = $urandom_range(8, 2);
          ns = $urandom_range(6);
        end
      endcase
      setup_paging(sh, np, tx, dt, nf, ns);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 83; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 83; end
        default: begin idle_pct = 11; stall_pct = 11; end
      endcase
      if (ph == 4) hold_req = 400;
      random_accesses(120, sh, np);
      drain();
    end

    idle_pct = 0;
    stall_pct = 0;
    repeat (50) @(negedge clk);
    $display("covered %0d results: %0d evictions, %0d writebacks, %0d swap refills",
             results_seen, evictions, writebacks, swap_fills);
    $display("%0d error statuses across 7 register settings", errors_seen);
    if (fails == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> demand_paging_frame_manager.f
+incdir+src
src/dpfm_pkg.sv
src/dpfm_ram.sv
src/demand_paging_frame_manager.sv
tb/dpfm_checker.sv
tb/demand_paging_frame_manager_tb.sv
